/* design/sba_pkg.sv */
// Package for the subnet address bitmap allocator.
// Field widths, operation and status codes, register indexes and the configuration struct.
// No dependencies; every other design file but sba_map_ram imports it.
package sba_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 13;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int WORD_BITS = 64;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
    localparam logic [OP_W-1:0] OP_EXCLUDE = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd3;

    // Status codes of a result word.
    localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
    localparam logic [ST_W-1:0] ST_DUP       = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [ST_W-1:0] ST_OUTSIDE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_ENABLED = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] pool_start;
        logic [SIZE_W-1:0] pool_size;
        logic              pool_enabled;
    } t_cfg;

endpackage

/* design/sba_op_if.sv */
// Input channel of the allocator: one operation word per handshake.
// Depends on sba_pkg for the field widths.
interface sba_op_if;
    import sba_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic              dynamic;
    logic [ADDR_W-1:0] range_first;
    logic [ADDR_W-1:0] range_last;

    modport source (
        output valid, operation, address, dynamic, range_first, range_last,
        input  ready
    );
    modport sink (
        input  valid, operation, address, dynamic, range_first, range_last,
        output ready
    );
endinterface

/* design/sba_res_if.sv */
// Result channel of the allocator: one result word per handshake.
// Depends on sba_pkg for the field widths.
interface sba_res_if;
    import sba_pkg::*;

    logic              valid;
    logic              ready;
    logic              accepted;
    logic [ST_W-1:0]   status;
    logic [ADDR_W-1:0] found_address;

    modport source (
        output valid, accepted, status, found_address,
        input  ready
    );
    modport sink (
        input  valid, accepted, status, found_address,
        output ready
    );
endinterface

/* design/sba_cfg_if.sv */
// Configuration write channel of the allocator: register index and write data.
// Depends on sba_pkg for the index and data widths.
interface sba_cfg_if;
    import sba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* design/sba_map_ram.sv */
// Used-address bitmap storage: 64-bit words, one write and one read port.
// The read data is registered, so it appears in the cycle after the read request.
module sba_map_ram #(
    parameter int WORDS = 64,
    localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [63:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_data
);
    logic [63:0] r_mem [WORDS];
    logic [63:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/sba_ctrl.sv */
// Operation sequencer of the allocator: decodes one word, walks the bitmap memory
// with read-modify-write passes and holds the result register. Depends on sba_pkg.
module sba_ctrl #(
    parameter int POOL_DEPTH = 4096,
    localparam int MAP_WORDS = (POOL_DEPTH + 63) / 64,
    localparam int WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sba_pkg::t_cfg    i_cfg,
    sba_op_if.sink           i_op,
    sba_res_if.source        o_res,
    output logic             o_ram_rd_en,
    output logic [WA_W-1:0]  o_ram_rd_addr,
    input  logic [63:0]      i_ram_rd_data,
    output logic             o_ram_wr_en,
    output logic [WA_W-1:0]  o_ram_wr_addr,
    output logic [63:0]      o_ram_wr_data
);
    import sba_pkg::*;

    localparam int NB = $clog2(POOL_DEPTH + 1);
    localparam int SW = (NB > SIZE_W) ? NB : SIZE_W;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_INS_CHK, S_INS_RD, S_INS_WR, S_EXC_CLAMP, S_EXC_SLOT,
        S_EXC_LOOP, S_FIND_SETUP, S_FIND_LOOP, S_FIND_ADD, S_DONE
    } t_state;

    function automatic logic [WA_W-1:0] word_of(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s >> 6;
        return t[WA_W-1:0];
    endfunction

    // Lowest set bit of a word, found by six halving steps.
    function automatic logic [5:0] ffs64(input logic [63:0] v);
        logic [63:0] x;
        logic [5:0]  idx;
        x   = v;
        idx = '0;
        for (int k = 5; k >= 0; k--) begin
            if ((x & ~({64{1'b1}} << (1 << k))) == 64'd0) begin
                idx[k] = 1'b1;
                x      = x >> (1 << k);
            end
        end
        return idx;
    endfunction

    t_state            r_state;
    logic [ADDR_W-1:0] r_addr;
    logic              r_dyn;
    logic [ADDR_W-1:0] r_first;
    logic [ADDR_W-1:0] r_last;
    logic [ADDR_W:0]   r_lo;
    logic [ADDR_W:0]   r_hi;
    logic [SW-1:0]     r_slot;
    logic [5:0]        r_lo_b;
    logic [5:0]        r_hi_b;
    logic [WA_W-1:0]   r_lo_w;
    logic [WA_W-1:0]   r_last_w;
    logic [WA_W-1:0]   r_idx;
    logic              r_rd_more;
    logic              r_pend;
    logic [WA_W-1:0]   r_pend_w;
    logic              r_mark0;
    logic              r_acc;
    logic [ST_W-1:0]   r_st;
    logic [ADDR_W-1:0] r_found;
    logic              r_out_valid;
    logic              r_out_acc;
    logic [ST_W-1:0]   r_out_st;
    logic [ADDR_W-1:0] r_out_found;

    logic [SW-1:0]   eff_n;
    logic [SW-1:0]   find_last;
    logic [ADDR_W:0] base33;
    logic [ADDR_W:0] lim33;
    logic [ADDR_W:0] first33;
    logic [ADDR_W:0] last1;
    logic            in_range;
    logic            ins_bit;
    logic [5:0]      lo_b;
    logic [5:0]      hi_b;
    logic [63:0]     exc_mask;
    logic [63:0]     lim_mask;
    logic [63:0]     free;
    logic            accept;

    assign accept    = i_op.valid && i_op.ready;
    assign i_op.ready = (r_state == S_IDLE);

    assign eff_n = (SW'(i_cfg.pool_size) > SW'(POOL_DEPTH)) ? SW'(POOL_DEPTH)
                                                             : SW'(i_cfg.pool_size);
    assign find_last = eff_n - SW'(2);
    assign base33    = {1'b0, i_cfg.pool_start};
    assign lim33     = base33 + (ADDR_W+1)'(eff_n);
    assign first33   = {1'b0, r_first};
    assign last1     = {1'b0, r_last} + 33'd1;
    assign in_range  = ({1'b0, r_addr} >= base33) && ({1'b0, r_addr} < lim33);
    assign ins_bit   = i_ram_rd_data[r_slot[5:0]];

    // Range mask of the word being written back during an exclude pass.
    assign lo_b     = (r_pend_w == r_lo_w) ? r_lo_b : 6'd0;
    assign hi_b     = (r_pend_w == r_last_w) ? r_hi_b : 6'd63;
    assign exc_mask = ({64{1'b1}} << lo_b) & ({64{1'b1}} >> (6'd63 - hi_b));
    assign lim_mask = (r_pend_w == r_last_w) ? ({64{1'b1}} >> (6'd63 - r_hi_b))
                                             : {64{1'b1}};
    assign free     = ~i_ram_rd_data & lim_mask;

    always_comb begin
        o_ram_rd_en   = 1'b0;
        o_ram_rd_addr = r_idx;
        o_ram_wr_en   = 1'b0;
        o_ram_wr_addr = r_pend_w;
        o_ram_wr_data = i_ram_rd_data | exc_mask;
        case (r_state)
            S_SWEEP: begin
                o_ram_wr_en   = 1'b1;
                o_ram_wr_addr = r_idx;
                o_ram_wr_data = (r_mark0 && r_idx == '0) ? 64'd1 : 64'd0;
            end
            S_INS_RD: begin
                o_ram_rd_en   = 1'b1;
                o_ram_rd_addr = word_of(r_slot);
            end
            S_INS_WR: begin
                o_ram_wr_en   = !(r_dyn && ins_bit);
                o_ram_wr_addr = word_of(r_slot);
                o_ram_wr_data = i_ram_rd_data | (64'd1 << r_slot[5:0]);
            end
            S_EXC_LOOP: begin
                o_ram_rd_en = r_rd_more;
                o_ram_wr_en = r_pend;
            end
            S_FIND_LOOP: begin
                o_ram_rd_en = r_rd_more;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_idx       <= '0;
            r_mark0     <= 1'b0;
            r_rd_more   <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // In S_DONE the output register is reloaded below instead.
            if (o_res.valid && o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            // Shared read pipeline of the exclude and find passes.
            if (r_state == S_EXC_LOOP || r_state == S_FIND_LOOP) begin
                if (r_rd_more) begin
                    r_pend   <= 1'b1;
                    r_pend_w <= r_idx;
                    if (r_idx == r_last_w) begin
                        r_rd_more <= 1'b0;
                    end else begin
                        r_idx <= r_idx + WA_W'(1);
                    end
                end else begin
                    r_pend <= 1'b0;
                end
            end

            case (r_state)
                S_SWEEP: begin
                    if (r_idx == WA_W'(MAP_WORDS - 1)) begin
                        r_acc   <= 1'b1;
                        r_st    <= ST_DONE;
                        r_found <= '0;
                        r_state <= r_mark0 ? S_DONE : S_IDLE;
                    end else begin
                        r_idx <= r_idx + WA_W'(1);
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_addr  <= i_op.address;
                        r_dyn   <= i_op.dynamic;
                        r_first <= i_op.range_first;
                        r_last  <= i_op.range_last;
                        r_found <= '0;
                        if (i_op.operation == OP_CLEAR) begin
                            r_idx   <= '0;
                            r_mark0 <= 1'b1;
                            r_state <= S_SWEEP;
                        end else if (!i_cfg.pool_enabled) begin
                            r_acc   <= (i_op.operation != OP_FIND);
                            r_st    <= ST_OUTSIDE;
                            r_state <= S_DONE;
                        end else begin
                            case (i_op.operation)
                                OP_INSERT:  r_state <= S_INS_CHK;
                                OP_EXCLUDE: r_state <= S_EXC_CLAMP;
                                default:    r_state <= S_FIND_SETUP;
                            endcase
                        end
                    end
                end
                S_INS_CHK: begin
                    r_slot <= SW'(r_addr - i_cfg.pool_start);
                    if (in_range) begin
                        r_state <= S_INS_RD;
                    end else begin
                        r_acc   <= 1'b1;
                        r_st    <= ST_OUTSIDE;
                        r_state <= S_DONE;
                    end
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    if (r_dyn && ins_bit) begin
                        r_acc <= 1'b0;
                        r_st  <= ST_DUP;
                    end else begin
                        r_acc <= 1'b1;
                        r_st  <= ST_DONE;
                    end
                    r_state <= S_DONE;
                end
                S_EXC_CLAMP: begin
                    r_lo    <= (first33 > base33) ? first33 : base33;
                    r_hi    <= (last1 > lim33) ? lim33 : last1;
                    r_state <= S_EXC_SLOT;
                end
                S_EXC_SLOT: begin
                    if (r_hi > r_lo) begin
                        r_lo_b    <= 6'(r_lo - base33);
                        r_hi_b    <= 6'(r_hi - base33 - 33'd1);
                        r_lo_w    <= word_of(SW'(r_lo - base33));
                        r_last_w  <= word_of(SW'(r_hi - base33 - 33'd1));
                        r_idx     <= word_of(SW'(r_lo - base33));
                        r_rd_more <= 1'b1;
                        r_pend    <= 1'b0;
                        r_state   <= S_EXC_LOOP;
                    end else begin
                        r_acc   <= 1'b0;
                        r_st    <= ST_OUTSIDE;
                        r_state <= S_DONE;
                    end
                end
                S_EXC_LOOP: begin
                    if (r_pend && !r_rd_more) begin
                        r_acc   <= 1'b1;
                        r_st    <= ST_DONE;
                        r_state <= S_DONE;
                    end
                end
                S_FIND_SETUP: begin
                    if (eff_n < SW'(2)) begin
                        r_acc   <= 1'b0;
                        r_st    <= ST_EXHAUSTED;
                        r_state <= S_DONE;
                    end else begin
                        r_hi_b    <= find_last[5:0];
                        r_last_w  <= word_of(find_last);
                        r_idx     <= '0;
                        r_rd_more <= 1'b1;
                        r_pend    <= 1'b0;
                        r_state   <= S_FIND_LOOP;
                    end
                end
                S_FIND_LOOP: begin
                    if (r_pend && free != 64'd0) begin
                        r_slot  <= (SW'(r_pend_w) << 6) | SW'(ffs64(free));
                        r_state <= S_FIND_ADD;
                    end else if (r_pend && !r_rd_more) begin
                        r_acc   <= 1'b0;
                        r_st    <= ST_EXHAUSTED;
                        r_state <= S_DONE;
                    end
                end
                S_FIND_ADD: begin
                    r_acc   <= 1'b1;
                    r_st    <= ST_DONE;
                    r_found <= i_cfg.pool_start + ADDR_W'(r_slot);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_acc   <= r_acc;
                        r_out_st    <= r_st;
                        r_out_found <= r_found;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.accepted      = r_out_acc;
    assign o_res.status        = r_out_st;
    assign o_res.found_address = r_out_found;

    // Each operation runs alone: no new word enters the cycle after one is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_op.ready)
        else $error("input taken while an operation is in flight");

    // The exclude pipeline never reads the word it is writing back.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_rd_en && o_ram_wr_en) |-> (o_ram_rd_addr != o_ram_wr_addr))
        else $error("bitmap read and write hit the same word");

    // Exclude writes stay inside the clamped word range.
    a_exc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXC_LOOP && o_ram_wr_en) |->
            (r_pend_w >= r_lo_w && r_pend_w <= r_last_w))
        else $error("exclude wrote outside its word range");

    // Only a successful find carries an address.
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != ST_DONE) |-> (r_out_found == '0))
        else $error("failed result carries an address");

endmodule

/* design/subnet_address_bitmap_allocator.sv */
// Exclude and find walk the bitmap one word per cycle through the memory read port.
// Throughput: one operation at a time; the next word is taken in the cycle after the result is
// registered, and a result held by the receiver keeps the input off until it can be registered.
// Reset: synchronous active-low; clears the registers, then sweeps the bitmap to zero while the
// input is held not ready (configuration writes still taken).
module subnet_address_bitmap_allocator #(
    parameter int POOL_DEPTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sba_op_if.sink    i_op,
    sba_res_if.source o_res,
    sba_cfg_if.sink   i_cfg
);
    import sba_pkg::*;

    // The bitmap holds one bit per pool slot, packed into 64-bit words.
    localparam int MAP_WORDS = (POOL_DEPTH + 63) / 64;
    localparam int WA_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    // Configuration registers. The write port never stalls; writes to an
    // index beyond the register list are taken and dropped.
    logic [ADDR_W-1:0] r_pool_start;
    logic [SIZE_W-1:0] r_pool_size;
    logic              r_pool_enabled;
    t_cfg              cfg;

    logic            ram_rd_en;
    logic [WA_W-1:0] ram_rd_addr;
    logic [63:0]     ram_rd_data;
    logic            ram_wr_en;
    logic [WA_W-1:0] ram_wr_addr;
    logic [63:0]     ram_wr_data;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_start   <= '0;
            r_pool_size    <= '0;
            r_pool_enabled <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_POOL_START:   r_pool_start   <= i_cfg.data;
                CFG_POOL_SIZE:    r_pool_size    <= i_cfg.data[SIZE_W-1:0];
                CFG_POOL_ENABLED: r_pool_enabled <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.pool_start   = r_pool_start;
    assign cfg.pool_size    = r_pool_size;
    assign cfg.pool_enabled = r_pool_enabled;

    // The sequencer owns all bitmap traffic. Only one operation is in flight,
    // and within an exclude pass each word is read once and written back in the
    // following cycle while the next word is read, so no two accesses to the same
    // word ever overlap and no forwarding is needed.
    sba_ctrl #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_op          (i_op),
        .o_res         (o_res),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data)
    );

    // Used-address bitmap with a registered read.
    sba_map_ram #(
        .WORDS (MAP_WORDS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data)
    );

endmodule

/* dv/tb_subnet_address_bitmap_allocator.sv */
// Testbench for the subnet address bitmap allocator: directed and random operation words,
// each result checked field by field against a behavioral predictor of the used-address map.
// Depends on sba_pkg, the op, result and config channel interfaces, and the allocator top level.
module tb_subnet_address_bitmap_allocator;
    import sba_pkg::*;

    // The map depth is passed down to the block so that both sides agree on it.
    localparam int POOL_DEPTH       = 4096;
    localparam int MAP_WORDS        = (POOL_DEPTH + WORD_BITS - 1) / WORD_BITS;
    // A find or an exclude can walk every map word, so this covers the slowest operation.
    localparam int SETTLE_CYCLES    = MAP_WORDS + 8;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_PHASES    = 16;
    localparam int PHASE_WORDS      = 50;

    // Index 3 is not a register; a write to it must leave every setting alone.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] address;
        logic              dynamic;
        logic [ADDR_W-1:0] range_first;
        logic [ADDR_W-1:0] range_last;
    } t_alloc_req;

    typedef struct packed {
        logic              accepted;
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] found_address;
    } t_alloc_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sba_op_if  op_if ();
    sba_res_if res_if ();
    sba_cfg_if cfg_if ();

    subnet_address_bitmap_allocator #(
        .POOL_DEPTH(POOL_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_op   (op_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: our own copy of the used map and of the three registers.
    bit                used_slots [POOL_DEPTH];
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] pool_slots;
    logic              pool_on;

    // Results predicted for accepted words, oldest first.
    t_alloc_res alloc_results_due [$];

    int errors          = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int op_count [4]    = '{0, 0, 0, 0};
    int dup_predicted   = 0;
    int exhaust_predicted = 0;
    int settings_used   = 0;
    int cycle_count     = 0;

    // Pacing controls. Only the main process writes these; the receiver only reads them.
    int sender_burst_left = 0;
    bit sender_steady     = 1'b0;
    bit receiver_steady   = 1'b0;
    int holds_requested   = 0;

    // Applies one operation word to the predicted map and returns the result it must produce.
    // Range and bound sums are done at 33 bits so that they never wrap; the found address wraps at 32.
    function automatic t_alloc_res apply_alloc_word(input t_alloc_req w);
        t_alloc_res      r;
        logic [ADDR_W:0] n;
        logic [ADDR_W:0] base33;
        logic [ADDR_W:0] lim;
        logic [ADDR_W:0] lo;
        logic [ADDR_W:0] hi;
        logic [ADDR_W:0] s;
        logic            hit;
        r.accepted      = 1'b1;
        r.status        = ST_DONE;
        r.found_address = '0;
        // Slots past the end of the map do not exist, whatever the register says.
        n      = (pool_slots < POOL_DEPTH) ? (ADDR_W+1)'(pool_slots)
                                           : (ADDR_W+1)'(POOL_DEPTH);
        base33 = {1'b0, pool_base};
        lim    = base33 + n;
        if (w.op == OP_CLEAR) begin
            // Clear works even on a disabled pool and reserves slot 0.
            foreach (used_slots[i]) used_slots[i] = 1'b0;
            used_slots[0] = 1'b1;
        end else if (!pool_on) begin
            r.status   = ST_OUTSIDE;
            r.accepted = (w.op != OP_FIND);
        end else if (w.op == OP_INSERT) begin
            if ({1'b0, w.address} >= base33 && {1'b0, w.address} < lim) begin
                s = {1'b0, w.address} - base33;
                if (w.dynamic && used_slots[s]) begin
                    r.accepted = 1'b0;
                    r.status   = ST_DUP;
                    dup_predicted++;
                end else begin
                    used_slots[s] = 1'b1;
                end
            end else begin
                r.status = ST_OUTSIDE;
            end
        end else if (w.op == OP_EXCLUDE) begin
            lo = ({1'b0, w.range_first} > base33) ? {1'b0, w.range_first} : base33;
            hi = {1'b0, w.range_last} + 1'b1;
            if (hi > lim) begin
                hi = lim;
            end
            if (hi > lo) begin
                for (s = lo - base33; s < hi - base33; s++) begin
                    used_slots[s] = 1'b1;
                end
            end else begin
                // An empty range after clamping, reversed bounds included.
                r.accepted = 1'b0;
                r.status   = ST_OUTSIDE;
            end
        end else begin
            // The last slot is never handed out, so the search stops one short of it.
            hit = 1'b0;
            s   = '0;
            while (!hit && s + 1 < n) begin
                if (!used_slots[s]) begin
                    hit = 1'b1;
                end else begin
                    s++;
                end
            end
            if (hit) begin
                r.found_address = pool_base + s[ADDR_W-1:0];
            end else begin
                r.accepted = 1'b0;
                r.status   = ST_EXHAUSTED;
                exhaust_predicted++;
            end
        end
        return r;
    endfunction

    function automatic t_alloc_req make_word(input logic [OP_W-1:0] op,
                                             input logic [ADDR_W-1:0] address,
                                             input logic dynamic,
                                             input logic [ADDR_W-1:0] range_first,
                                             input logic [ADDR_W-1:0] range_last);
        t_alloc_req w;
        w.op          = op;
        w.address     = address;
        w.dynamic     = dynamic;
        w.range_first = range_first;
        w.range_last  = range_last;
        return w;
    endfunction

    // Random word aimed at the current pool: most addresses and ranges land in or just around
    // the pool so that the map fills up, the rest is noise over the whole address space.
    function automatic t_alloc_req random_alloc_word();
        t_alloc_req  w;
        int unsigned pick;
        int unsigned span;
        span          = (pool_slots < POOL_DEPTH) ? pool_slots : POOL_DEPTH;
        pick          = $urandom_range(0, 99);
        w.op          = OP_FIND;
        w.address     = $urandom;
        w.dynamic     = 1'($urandom_range(0, 1));
        w.range_first = $urandom;
        w.range_last  = $urandom;
        if (pick < 4) begin
            w.op = OP_CLEAR;
        end else if (pick < 48) begin
            w.op = OP_INSERT;
            if ($urandom_range(0, 9) != 0) begin
                // From one below the pool to one past its end.
                w.address = pool_base + $urandom_range(0, span + 1) - 1;
            end
        end else if (pick < 66) begin
            w.op = OP_EXCLUDE;
            case ($urandom_range(0, 9))
                0: begin
                    // Fully random bounds.
                end
                1: begin
                    w.range_last = w.range_first - 1 - $urandom_range(0, 7);
                end
                2: begin
                    w.range_first = pool_base - $urandom_range(0, 3);
                    w.range_last  = pool_base + span + $urandom_range(0, 3);
                end
                default: begin
                    w.range_first = pool_base + $urandom_range(0, span);
                    w.range_last  = w.range_first + $urandom_range(0, 12);
                end
            endcase
        end
        return w;
    endfunction

    // Offers one word and waits for its handshake. The sender works in bursts; between bursts
    // valid may drop for a random gap. Valid stays high after a handshake so that back-to-back
    // words within a burst need no idle cycle.
    task automatic send_word(input t_alloc_req w);
        int gap;
        if (sender_burst_left == 0) begin
            sender_burst_left = $urandom_range(1, 12);
            gap = sender_steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                op_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        sender_burst_left--;
        @(negedge i_clk);
        op_if.valid       = 1'b1;
        op_if.operation   = w.op;
        op_if.address     = w.address;
        op_if.dynamic     = w.dynamic;
        op_if.range_first = w.range_first;
        op_if.range_last  = w.range_last;
        do @(posedge i_clk); while (!op_if.ready);
        alloc_results_due.push_back(apply_alloc_word(w));
        words_sent++;
        op_count[w.op]++;
    endtask

    // Drops valid and waits until every predicted result has been seen, then lets the
    // longest walk finish so that the block is fully idle.
    task automatic drain_results();
        @(negedge i_clk);
        op_if.valid = 1'b0;
        sender_burst_left = 0;
        while (alloc_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = data;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_POOL_START:   pool_base  = data;
            CFG_POOL_SIZE:    pool_slots = data[SIZE_W-1:0];
            CFG_POOL_ENABLED: pool_on    = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    // Registers are only rewritten once the block has gone idle.
    task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] size_word,
                            input logic enable);
        drain_results();
        write_reg(CFG_POOL_START, base);
        write_reg(CFG_POOL_SIZE, size_word);
        write_reg(CFG_POOL_ENABLED, {{(ADDR_W-1){1'b0}}, enable});
        settings_used++;
    endtask

    // Right after reset the pool is disabled and the map is empty, not yet holding slot 0.
    task automatic test_reset_state();
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, '0, 1'b1, '0, '0));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, '0, '1));
        drain_results();
        write_reg(CFG_UNUSED, '1);
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        set_pool(32'h0000_0000, 32'd4096, 1'b1);
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_CLEAR, '0, 1'b0, '0, '0));
    endtask

    task automatic test_insert_and_exclude();
        logic [ADDR_W-1:0] b;
        b = 32'h0A00_0001;
        set_pool(b, 32'd16, 1'b1);
        send_word(make_word(OP_CLEAR, '0, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, b + 3, 1'b1, '0, '0));
        send_word(make_word(OP_INSERT, b + 3, 1'b1, '0, '0));
        send_word(make_word(OP_INSERT, b + 3, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, b - 1, 1'b1, '0, '0));
        send_word(make_word(OP_INSERT, b + 16, 1'b1, '0, '0));
        send_word(make_word(OP_INSERT, b + 15, 1'b1, '0, '0));
        // Reversed bounds, a range wholly below the pool and one wholly above it.
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, b + 5, b + 4));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, 32'h0, b - 1));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, b + 16, '1));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, 32'h0, b + 5));
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, b + 6, '1));
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
    endtask

    task automatic test_pool_extremes();
        // A pool that claims more slots than the map holds, based at the top address:
        // the first free slot after a clear sits past 2^32 and wraps to zero.
        set_pool(32'hFFFF_FFFF, 32'd8191, 1'b1);
        send_word(make_word(OP_CLEAR, '0, 1'b0, '0, '0));
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, 32'hFFFF_FFFF, 1'b1, '0, '0));
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, 32'h0, '1));
        // Junk above the size field must be dropped.
        set_pool(32'h0000_0000, 32'hFFFF_1000, 1'b1);
        send_word(make_word(OP_EXCLUDE, '0, 1'b0, 32'd1, 32'd4094));
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, 32'd4095, 1'b1, '0, '0));
        // Pools of zero and one slot never have a slot to hand out.
        set_pool(32'd100, 32'd0, 1'b1);
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
        send_word(make_word(OP_INSERT, 32'd100, 1'b0, '0, '0));
        set_pool(32'd100, 32'd1, 1'b1);
        send_word(make_word(OP_FIND, '0, 1'b0, '0, '0));
    endtask

    // The receiver holds off for a long stretch while words keep coming, so the block backs
    // up and must stall its input; afterwards the sender waits for every result.
    task automatic test_backpressure();
        set_pool($urandom, 32'd64, 1'b1);
        sender_steady = 1'b1;
        holds_requested++;
        send_word(make_word(OP_CLEAR, '0, 1'b0, '0, '0));
        repeat (30) send_word(random_alloc_word());
        sender_steady = 1'b0;
        drain_results();
    endtask

    // Each phase picks a pool, starts from a clear and then runs mostly pool-directed words.
    task automatic test_random_phases();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size_word;
        int unsigned       size;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0:       base = 32'h0000_0000;
                1:       base = 32'hFFFF_FFFF - $urandom_range(0, 64);
                2, 3:    base = $urandom;
                default: base = $urandom_range(1, 1000);
            endcase
            case ($urandom_range(0, 19))
                0:          size = $urandom_range(0, 2);
                1:          size = 4096;
                2:          size = $urandom_range(4097, 8191);
                3, 4, 5:    size = $urandom_range(65, 600);
                default:    size = $urandom_range(3, 64);
            endcase
            size_word = size;
            if ($urandom_range(0, 3) == 0) begin
                size_word = ($urandom & ~32'h1FFF) | size;
            end
            set_pool(base, size_word, $urandom_range(0, 9) != 0);
            sender_steady   = (p % 4 == 1);
            receiver_steady = (p % 4 == 2);
            send_word(make_word(OP_CLEAR, '0, 1'b0, '0, '0));
            repeat (PHASE_WORDS - 1) send_word(random_alloc_word());
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    // Result receiver. It stalls in runs of random length, can be told to hold off for a
    // long stretch, and is always ready during steady phases.
    initial begin : result_receiver
        int hold_left;
        int holds_served;
        int run_left;
        bit stalling;
        hold_left    = 0;
        holds_served = 0;
        run_left     = 0;
        stalling     = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_requested) begin
                holds_served++;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready = 1'b0;
                hold_left--;
            end else if (receiver_steady) begin
                res_if.ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    stalling = !stalling;
                    run_left = stalling ? $urandom_range(1, 6) : $urandom_range(1, 10);
                end
                run_left--;
                res_if.ready = !stalling;
            end
        end
    end

    // Every result word handed over is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_alloc_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (alloc_results_due.size() == 0) begin
                $display("%0t: result with nothing expected: accepted %0b status %0d found %0h",
                         $time, res_if.accepted, res_if.status, res_if.found_address);
                errors++;
            end else begin
                want = alloc_results_due.pop_front();
                results_checked++;
                if (res_if.accepted !== want.accepted) begin
                    $display("%0t: accepted mismatch: expected %0b actual %0b",
                             $time, want.accepted, res_if.accepted);
                    errors++;
                end
                if (res_if.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, res_if.status);
                    errors++;
                end
                if (res_if.found_address !== want.found_address) begin
                    $display("%0t: found_address mismatch: expected %08h actual %08h",
                             $time, want.found_address, res_if.found_address);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a correct run ends far inside this budget.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d results outstanding",
                     $time, alloc_results_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Every input is known from time zero; the model starts from the reset state.
        i_rst_n           = 1'b0;
        op_if.valid       = 1'b0;
        op_if.operation   = OP_CLEAR;
        op_if.address     = '0;
        op_if.dynamic     = 1'b0;
        op_if.range_first = '0;
        op_if.range_last  = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_POOL_START;
        cfg_if.data       = '0;
        foreach (used_slots[i]) used_slots[i] = 1'b0;
        pool_base  = '0;
        pool_slots = '0;
        pool_on    = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_insert_and_exclude();
        test_pool_extremes();
        test_backpressure();
        test_random_phases();
        drain_results();

        $display("Sent %0d words (clear %0d, insert %0d, exclude %0d, find %0d), checked %0d results.",
                 words_sent, op_count[OP_CLEAR], op_count[OP_INSERT], op_count[OP_EXCLUDE],
                 op_count[OP_FIND], results_checked);
        $display("Used %0d pool settings; %0d duplicate inserts and %0d exhausted finds predicted.",
                 settings_used, dup_predicted, exhaust_predicted);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/sba_pkg.sv
design/sba_op_if.sv
design/sba_res_if.sv
design/sba_cfg_if.sv
design/sba_map_ram.sv
design/sba_ctrl.sv
design/subnet_address_bitmap_allocator.sv
dv/tb_subnet_address_bitmap_allocator.sv
